### hw/rtl/qrg_pkg.sv
// Shared types and constants for the quantizer reciprocal generator.
// No dependencies.
`timescale 1ns / 1ps

package qrg_pkg;

  localparam int unsigned EntryW     = 13;  // table entry width
  localparam int unsigned RemW       = 13;  // partial remainder, as wide as the entry
  localparam int unsigned QuotW      = 32;  // quotient bits produced
  localparam int unsigned NarrowW    = 16;
  localparam int unsigned CorrW      = 15;
  localparam int unsigned ShiftW     = 4;
  localparam int unsigned ScaleW     = 15;
  localparam int unsigned BitsPerStg = 4;   // division steps per pipeline stage
  localparam int unsigned NumStg     = QuotW / BitsPerStg;
  localparam int unsigned NarrowStg  = NarrowW / BitsPerStg - 1;  // stage that ends the 16-bit quotient

  // Divider pipeline payload. en is the entry normalized so its top bit is bit 12.
  typedef struct packed {
    logic              valid;
    logic              zero;
    logic              pow2;
    logic [3:0]        top;
    logic [EntryW-1:0] entry;
    logic [EntryW-1:0] en;
    logic [RemW-1:0]   rem;
    logic [RemW-1:0]   rem_narrow;
    logic [QuotW-1:0]  quot;
  } div_t;

endpackage

### hw/rtl/qrg_div_stage.sv
// One register stage of the restoring divider: BitsPerStg quotient bits.
// Depends on qrg_pkg.
`timescale 1ns / 1ps

module qrg_div_stage
  import qrg_pkg::*;
#(
  parameter bit CaptureNarrow = 1'b0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  div_t stg_i,
  output div_t stg_o
);

  div_t        stg_d, stg_q;
  logic [RemW:0] dbl;
  logic [RemW-1:0] rem;
  logic [QuotW-1:0] quot;

  // shift-compare-subtract steps
  always_comb begin
    rem  = stg_i.rem;
    quot = stg_i.quot;
    dbl  = '0;
    for (int k = 0; k < BitsPerStg; k++) begin
      dbl = {rem, 1'b0};
      if (dbl >= {1'b0, stg_i.en}) begin
        rem  = RemW'(dbl - {1'b0, stg_i.en});
        quot = {quot[QuotW-2:0], 1'b1};
      end else begin
        rem  = dbl[RemW-1:0];
        quot = {quot[QuotW-2:0], 1'b0};
      end
    end
    stg_d      = stg_i;
    stg_d.rem  = rem;
    stg_d.quot = quot;
    if (CaptureNarrow) begin
      stg_d.rem_narrow = rem;
    end
  end

  // stage register; reset clears the valid bit, data holds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q.valid <= 1'b0;
    end else begin
      stg_q <= stg_d;
    end
  end

  assign stg_o = stg_q;

endmodule

### hw/rtl/quant_reciprocal_generator.sv
// Top level: reciprocal and rounding constants for one quantization entry.
// Depends on qrg_pkg and qrg_div_stage.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+-------------------------
//  command | table_entry_i                          | start_i, busy_o (always 0)
//  result  | recip_*_o, corr_*_o, post_shift_o,     | done_o, one-cycle strobe
//          | scale_narrow_o                         |
//
// One entry may start every cycle; each result appears once its transfer has
// passed one normalize stage, eight divider stages of four restoring steps
// each (32 quotient bits) and one rounding stage. Reset clears only the valid
// bits. The result side cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps

module quant_reciprocal_generator
  import qrg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [EntryW-1:0] table_entry_i,
  output logic              done_o,
  output logic [QuotW-1:0]  recip_wide_o,
  output logic [CorrW-1:0]  corr_wide_o,
  output logic [NarrowW-1:0] recip_narrow_o,
  output logic [CorrW-1:0]  corr_narrow_o,
  output logic [ShiftW-1:0] post_shift_o,
  output logic [ScaleW-1:0] scale_narrow_o
);

  div_t pipe [NumStg+1];
  div_t front_d, front_q;
  logic [3:0] top;

  assign busy_o = 1'b0;

  // normalize: top set bit, power-of-two and zero detection
  always_comb begin
    top = '0;
    for (int i = 0; i < EntryW; i++) begin
      if (table_entry_i[i]) top = 4'(i);
    end
    front_d.valid      = start_i;
    front_d.zero       = (table_entry_i == '0);
    front_d.pow2       = ((table_entry_i & (table_entry_i - 1'b1)) == '0);
    front_d.top        = top;
    front_d.entry      = table_entry_i;
    front_d.en         = table_entry_i << (4'(EntryW - 1) - top);
    front_d.rem        = RemW'(1) << (RemW - 1);  // 2^44 reduced by the first 13 steps
    front_d.rem_narrow = '0;
    front_d.quot       = '0;
  end

  // front register; reset clears the valid bit, data holds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q.valid <= 1'b0;
    end else begin
      front_q <= front_d;
    end
  end

  assign pipe[0] = front_q;

  // divider stages
  for (genvar s = 0; s < NumStg; s++) begin : g_div
    qrg_div_stage #(
      .CaptureNarrow(s == NarrowStg)
    ) u_stage (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .stg_i (pipe[s]),
      .stg_o (pipe[s+1])
    );
  end

  // rounding and output register
  div_t             last;
  logic             done_q;
  logic [QuotW-1:0] rw_d, rw_q;
  logic [CorrW-1:0] cw_d, cw_q, cn_d, cn_q, half;
  logic [NarrowW-1:0] rn_d, rn_q;
  logic [ShiftW-1:0] sh_d, sh_q;
  logic [ScaleW-1:0] sc_d, sc_q;
  logic             up_w, up_n;

  assign last = pipe[NumStg];

  always_comb begin
    half = {last.entry, 2'b00};
    up_w = ({last.rem, 1'b0} > {1'b0, last.en});
    up_n = ({last.rem_narrow, 1'b0} > {1'b0, last.en});
    if (last.zero) begin
      rw_d = '0; cw_d = '0; rn_d = '0; cn_d = '0; sh_d = '0; sc_d = '0;
    end else if (last.pow2) begin
      rw_d = QuotW'(1) << (QuotW - 1);
      rn_d = NarrowW'(1) << (NarrowW - 1);
      cw_d = half;
      cn_d = half;
      sh_d = last.top + 4'd2;
      sc_d = ScaleW'(1) << (5'd16 - {1'b0, sh_d});
    end else begin
      rw_d = last.quot + QuotW'(up_w);
      rn_d = last.quot[QuotW-1 -: NarrowW] + NarrowW'(up_n);
      cw_d = half + CorrW'(!up_w);
      cn_d = half + CorrW'(!up_n);
      sh_d = last.top + 4'd3;
      sc_d = ScaleW'(1) << (5'd16 - {1'b0, sh_d});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rw_q <= rw_d;
    cw_q <= cw_d;
    rn_q <= rn_d;
    cn_q <= cn_d;
    sh_q <= sh_d;
    sc_q <= sc_d;
  end

  assign done_o         = done_q;
  assign recip_wide_o   = rw_q;
  assign corr_wide_o    = cw_q;
  assign recip_narrow_o = rn_q;
  assign corr_narrow_o  = cn_q;
  assign post_shift_o   = sh_q;
  assign scale_narrow_o = sc_q;

endmodule

### hw/rtl/qrg_checker.sv
// Port-level checks for the quantizer reciprocal generator, bound to the top.
// Depends on qrg_pkg.
`timescale 1ns / 1ps

module qrg_checker
  import qrg_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic [NarrowW-1:0] recip_narrow_o,
  input logic [ShiftW-1:0]  post_shift_o,
  input logic [ScaleW-1:0]  scale_narrow_o
);

  // each transfer yields a result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##10 done_o) else $error("result missing");

  // no result without a transfer
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 10)) else $error("spurious result");

  // scale matches the shift
  a_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && post_shift_o != '0) |->
      scale_narrow_o == (ScaleW'(1) << (5'd16 - {1'b0, post_shift_o})))
    else $error("scale mismatch");

  // zero entry gives zero shift and zero reciprocal together
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((recip_narrow_o == '0) == (post_shift_o == '0)))
    else $error("zero result inconsistent");

endmodule

bind quant_reciprocal_generator qrg_checker u_qrg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .recip_narrow_o(recip_narrow_o),
  .post_shift_o  (post_shift_o),
  .scale_narrow_o(scale_narrow_o)
);

### tb/sv/tb_quant_reciprocal_generator.sv
// Testbench for quant_reciprocal_generator: random and corner quantization entries,
// results predicted per entry and checked in order. Depends on qrg_pkg and the RTL.
`timescale 1ns / 1ps

module tb_quant_reciprocal_generator;
  import qrg_pkg::*;

  typedef struct packed {
    logic [QuotW-1:0]   recip_wide;
    logic [CorrW-1:0]   corr_wide;
    logic [NarrowW-1:0] recip_narrow;
    logic [CorrW-1:0]   corr_narrow;
    logic [ShiftW-1:0]  post_shift;
    logic [ScaleW-1:0]  scale_narrow;
  } recip_res_t;

  // Expected constants for one entry
  function automatic recip_res_t recip_predict(logic [EntryW-1:0] entry);
    recip_res_t res;
    logic [15:0] dv;
    int unsigned msb;
    int unsigned ex;
    longint unsigned num, quo, rmd, half, cr;
    res = '0;
    dv = {entry, 3'b000};
    if (dv != 0) begin
      msb = 0;
      for (int i = 0; i < 16; i++) if (dv[i]) msb = i;
      half = dv >> 1;
      // wide and narrow paths, numerator 2^(32+msb) or 2^(16+msb) fits 64 bits
      for (int w = 0; w < 2; w++) begin
        ex = (w == 0 ? 32 : 16) + msb;
        num = 64'd1 << ex;
        quo = num / dv;
        rmd = num % dv;
        cr = half;
        if (rmd == 0) begin
          quo = quo >> 1;
          ex--;
        end else if (rmd <= half) cr++;
        else quo++;
        if (w == 0) begin
          res.recip_wide = quo[31:0];
          res.corr_wide = cr[14:0];
          res.post_shift = ShiftW'(ex - 32);
        end else begin
          res.recip_narrow = quo[15:0];
          res.corr_narrow = cr[14:0];
          res.scale_narrow = ScaleW'((ex - 16 <= 16) ?
                                     ((32'd1 << (32 - ex)) & 32'h7FFF) : 32'd0);
        end
      end
    end
    return res;
  endfunction

  class recip_scoreboard;
    recip_res_t pending[$];
    int errors = 0;

    function void note_entry(logic [EntryW-1:0] entry);
      pending.push_back(recip_predict(entry));
    endfunction

    function void check_result(recip_res_t got);
      recip_res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp rw=%h cw=%h rn=%h cn=%h sh=%0d sc=%h",
                    " got rw=%h cw=%h rn=%h cn=%h sh=%0d sc=%h"},
                   want.recip_wide, want.corr_wide, want.recip_narrow, want.corr_narrow,
                   want.post_shift, want.scale_narrow, got.recip_wide, got.corr_wide,
                   got.recip_narrow, got.corr_narrow, got.post_shift, got.scale_narrow);
      end
    endfunction
  endclass

  localparam int WdogLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [EntryW-1:0] table_entry_i = '0;
  logic busy_o, done_o;
  logic [QuotW-1:0] recip_wide_o;
  logic [CorrW-1:0] corr_wide_o;
  logic [NarrowW-1:0] recip_narrow_o;
  logic [CorrW-1:0] corr_narrow_o;
  logic [ShiftW-1:0] post_shift_o;
  logic [ScaleW-1:0] scale_narrow_o;

  recip_scoreboard sb = new();
  int idle_cycles = 0;

  quant_reciprocal_generator u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sample transfers on both sides at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_entry(table_entry_i);
      if (done_o)
        sb.check_result({recip_wide_o, corr_wide_o, recip_narrow_o, corr_narrow_o,
                         post_shift_o, scale_narrow_o});
      if ((start_i && !busy_o) || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WdogLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Send one entry; start stays high across back-to-back transfers
  task automatic send_entry(logic [EntryW-1:0] entry, bit keep_gaps);
    int gap;
    start_i <= 1'b1;
    table_entry_i <= entry;
    do @(posedge clk_i); while (busy_o);
    if (keep_gaps) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        start_i <= 1'b0;
        table_entry_i <= EntryW'($urandom);
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [EntryW-1:0] e;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Corners: zero entry, extremes, powers of two, near powers of two, alternating bit patterns
    send_entry(0, 0);
    send_entry(1, 0);
    send_entry(8191, 0);
    send_entry(4096, 1);
    send_entry(4095, 0);
    send_entry(2, 0);
    send_entry(3, 1);
    send_entry(5, 0);
    send_entry(255, 0);
    send_entry(256, 0);
    send_entry(257, 1);
    send_entry(13'h1555, 0);
    send_entry(13'h0AAA, 0);
    send_entry(1024, 0);
    send_entry(7, 1);
    start_i <= 1'b0;
    @(posedge clk_i);
    // Hold the sender until the pipeline is empty
    drain();
    for (int n = 0; n < 1800; n++) begin
      case ($urandom_range(0, 3))
        0: e = EntryW'(1) << $urandom_range(0, 12);
        1: e = EntryW'($urandom_range(1, 31));
        default: e = EntryW'($urandom);
      endcase
      send_entry(e, n < 600 || n >= 1200);
      if (n == 900) begin
        start_i <= 1'b0;
        @(posedge clk_i);
        drain();
      end
    end
    start_i <= 1'b0;
    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/qrg_pkg.sv
hw/rtl/qrg_div_stage.sv
hw/rtl/quant_reciprocal_generator.sv
hw/rtl/qrg_checker.sv
tb/sv/tb_quant_reciprocal_generator.sv
